FILE: hw/rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// RPN stack calculator package
// Shared constants, command and status codes, and the control state type.
// ----------------------------------------------------------------------------
package rpn_pkg;

  // Stack geometry.
  localparam int STACK_DEPTH = 2048;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Field widths of the channels.
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int DEPTH_OUT_W = 12;

  // Command codes. Codes six and seven are no operation.
  localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PRINT = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_DIVZ  = 2'd3;

  // Control sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_OPER,
    S_DIVW,
    S_WB,
    S_REFILL,
    S_EMIT
  } state_t;

endpackage

FILE: hw/rtl/rpn_ifs.sv
// ----------------------------------------------------------------------------
// RPN stack calculator channels
// Valid/ready channel interfaces for instructions and results.
// ----------------------------------------------------------------------------
interface rpn_in_if;
  logic                              valid;
  logic                              ready;
  logic [rpn_pkg::CMD_W-1:0]         cmd;
  logic signed [rpn_pkg::DATA_W-1:0] operand;

  modport source (output valid, output cmd, output operand, input ready);
  modport sink   (input valid, input cmd, input operand, output ready);
endinterface

interface rpn_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [rpn_pkg::STATUS_W-1:0]         status;
  logic                                 printed;
  logic signed [rpn_pkg::DATA_W-1:0]    result_value;
  logic [rpn_pkg::DEPTH_OUT_W-1:0]      stack_depth;

  modport source (output valid, output status, output printed, output result_value,
                  output stack_depth, input ready);
  modport sink   (input valid, input status, input printed, input result_value,
                  input stack_depth, output ready);
endinterface

FILE: hw/rtl/rpn_ram.sv
// ----------------------------------------------------------------------------
// RPN stack memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/rpn_div.sv
// ----------------------------------------------------------------------------
// RPN signed divider
// Radix-2 restoring divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module rpn_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rpn_pkg::DATA_W-1:0] dividend,
  input  logic [rpn_pkg::DATA_W-1:0] divisor,
  output logic                      done,
  output logic [rpn_pkg::DATA_W-1:0] quotient
);
  import rpn_pkg::*;

  localparam int ITER_W = $clog2(DATA_W);

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] dvs_r;
  logic              neg_r;

  logic [DATA_W-1:0] abs_a;
  logic [DATA_W-1:0] abs_b;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;

  assign abs_a   = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
  assign abs_b   = divisor[DATA_W-1]  ? (DATA_W'(0) - divisor)  : divisor;
  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= abs_a;
        dvs_r  <= abs_b;
        neg_r  <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_r) begin
        if (!trial[DATA_W]) begin
          rem_r <= trial[DATA_W-1:0];
          quo_r <= {quo_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[DATA_W-1:0];
          quo_r <= {quo_r[DATA_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + ITER_W'(1);
        if (cnt_r == ITER_W'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (DATA_W'(0) - quo_r) : quo_r;

endmodule

FILE: hw/rtl/rpn_stack_calculator_unit.sv
// ----------------------------------------------------------------------------
// RPN stack calculator unit
// Postfix stack machine: push, add, subtract, multiply, divide and print.
// ----------------------------------------------------------------------------
// The unit takes one instruction transaction at a time and returns exactly one
// result transaction for it. The stack lives in a 2048-entry synchronous RAM;
// the current top entry is also held in a register so that push, print and
// the error cases need no memory read to form their result. Push, no-op and
// every error case go from acceptance straight to the emit state; a print of
// more than one entry first passes the refill state, which reloads the new top
// from RAM; add, subtract and multiply pass the operate and write-back states,
// and divide also waits in the divide-wait state for the divider, which makes
// one quotient bit per cycle. The next instruction can be accepted in the same
// cycle that its predecessor's result is offered. The next instruction is
// accepted once the previous one has left the sequencer, even while its
// result still waits in the output register. Stack contents need no clearing
// after reset: only entries that were pushed since reset are read.
module rpn_stack_calculator_unit (
  input  logic      clk,
  input  logic      rst_n,
  rpn_in_if.sink    in_chan,
  rpn_out_if.source out_chan
);
  import rpn_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Architectural state: entry count and a copy of the top entry.
  logic [CNT_W-1:0]  count_r;
  logic [DATA_W-1:0] top_r;

  // Instruction being worked on and the pending result.
  logic [CMD_W-1:0]    cmd_r;
  logic [DATA_W-1:0]   wb_r;
  logic [STATUS_W-1:0] status_r;
  logic                printed_r;
  logic [DATA_W-1:0]   value_r;
  logic [CNT_W-1:0]    depth_r;

  // Output register.
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_printed_r;
  logic [DATA_W-1:0]   out_value_r;
  logic [CNT_W-1:0]    out_depth_r;

  // Memory and divider hookup.
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_q;

  logic              in_ready;
  logic              accept;
  logic              is_arith;
  logic              is_full;
  logic              too_few;
  logic              is_empty;
  logic              out_free;
  logic [DATA_W-1:0] top_z;
  logic [ADDR_W-1:0] second_addr;

  assign accept   = in_chan.valid & in_ready;
  assign is_arith = (in_chan.cmd == CMD_ADD) || (in_chan.cmd == CMD_SUB) ||
                    (in_chan.cmd == CMD_MUL) || (in_chan.cmd == CMD_DIV);
  assign is_full  = (count_r == CNT_W'(STACK_DEPTH));
  assign too_few  = (count_r < CNT_W'(2));
  assign is_empty = (count_r == '0);
  assign out_free = !out_valid_r || out_chan.ready;
  assign top_z    = is_empty ? '0 : top_r;

  // Both the left operand of arithmetic and the new top after a print sit one
  // below the current top, so the read address is always the same.
  assign second_addr = ADDR_W'(count_r - CNT_W'(2));

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          priority if (is_arith && !too_few &&
                       !((in_chan.cmd == CMD_DIV) && (top_r == '0))) begin
            state_nxt = S_OPER;
          end else if ((in_chan.cmd == CMD_PRINT) && (count_r > CNT_W'(1))) begin
            state_nxt = S_REFILL;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_OPER: begin
        state_nxt = (cmd_r == CMD_DIV) ? S_DIVW : S_WB;
      end
      S_DIVW: begin
        if (div_done) begin
          state_nxt = S_WB;
        end
      end
      S_WB:     state_nxt = S_EMIT;
      S_REFILL: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    div_start = (state_r == S_OPER) && (cmd_r == CMD_DIV);
    mem_raddr = second_addr;
    mem_we    = 1'b0;
    mem_waddr = ADDR_W'(count_r);
    mem_wdata = in_chan.operand;
    unique case (state_r)
      S_IDLE: begin
        mem_we = accept && (in_chan.cmd == CMD_PUSH) && !is_full;
      end
      S_WB: begin
        // The result replaces the left operand, which becomes the new top.
        mem_we    = 1'b1;
        mem_waddr = second_addr;
        mem_wdata = wb_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Datapath and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if ((state_r == S_EMIT) && out_free) begin
        out_valid_r   <= 1'b1;
        out_status_r  <= status_r;
        out_printed_r <= printed_r;
        out_value_r   <= value_r;
        out_depth_r   <= depth_r;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r     <= in_chan.cmd;
            status_r  <= STAT_OK;
            printed_r <= 1'b0;
            value_r   <= top_z;
            depth_r   <= count_r;
            if (in_chan.cmd == CMD_PUSH) begin
              if (is_full) begin
                status_r <= STAT_FULL;
              end else begin
                top_r   <= in_chan.operand;
                count_r <= count_r + CNT_W'(1);
                value_r <= in_chan.operand;
                depth_r <= count_r + CNT_W'(1);
              end
            end else if (is_arith) begin
              if (too_few) begin
                status_r <= STAT_UNDER;
              end else if ((in_chan.cmd == CMD_DIV) && (top_r == '0)) begin
                status_r <= STAT_DIVZ;
              end
            end else if (in_chan.cmd == CMD_PRINT) begin
              if (is_empty) begin
                status_r <= STAT_UNDER;
                value_r  <= '0;
              end else begin
                printed_r <= 1'b1;
                value_r   <= top_r;
                count_r   <= count_r - CNT_W'(1);
                depth_r   <= count_r - CNT_W'(1);
              end
            end
          end
        end
        S_OPER: begin
          // Left operand arrives from RAM; the right one is the cached top.
          unique case (cmd_r)
            CMD_ADD: wb_r <= mem_rdata + top_r;
            CMD_SUB: wb_r <= mem_rdata - top_r;
            CMD_MUL: wb_r <= mem_rdata * top_r;
            default: wb_r <= wb_r;
          endcase
        end
        S_DIVW: begin
          if (div_done) begin
            wb_r <= div_q;
          end
        end
        S_WB: begin
          top_r    <= wb_r;
          count_r  <= count_r - CNT_W'(1);
          value_r  <= wb_r;
          depth_r  <= count_r - CNT_W'(1);
        end
        S_REFILL: begin
          top_r <= mem_rdata;
        end
        default: begin
          top_r <= top_r;
        end
      endcase
    end
  end

  rpn_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mem_rdata),
    .divisor  (top_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_chan.ready         = in_ready;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.printed      = out_printed_r;
  assign out_chan.result_value = out_value_r;
  assign out_chan.stack_depth  = DEPTH_OUT_W'(out_depth_r);

endmodule

FILE: verif/rpn_result_checker.sv
// ----------------------------------------------------------------------------
// RPN calculator result checker
// Watches both channels, keeps a private copy of the data stack, predicts one
// result per accepted instruction and compares every result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  rpn_in_if           in_mon,
  rpn_out_if          out_mon,
  output int unsigned mismatch_count,
  output int unsigned results_owed
);
  import rpn_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     printed;
    logic signed [DATA_W-1:0] value;
    logic [DEPTH_OUT_W-1:0]   depth;
  } calc_result_t;

  localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
  localparam int MAX_REPORTED = 60;

  logic signed [DATA_W-1:0] stack_copy [STACK_DEPTH];
  int unsigned              stack_count;
  calc_result_t             owed_q [$];
  int unsigned              errors = 0;

  assign mismatch_count = errors;

  function automatic logic signed [DATA_W-1:0] top_value();
    return (stack_count == 0) ? '0 : stack_copy[stack_count-1];
  endfunction

  // Executes one instruction on the private stack and returns its result.
  function automatic calc_result_t apply_instruction(logic [CMD_W-1:0] cmd,
                                                     logic signed [DATA_W-1:0] operand);
    calc_result_t             r;
    logic signed [DATA_W-1:0] lhs;
    logic signed [DATA_W-1:0] rhs;
    logic signed [DATA_W-1:0] res;
    logic                     res_ok;
    r.status = STAT_OK;
    r.printed = 1'b0;
    r.value = '0;
    res = '0;
    res_ok = 1'b1;
    if (cmd == CMD_PUSH) begin
      if (stack_count >= STACK_DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        stack_copy[stack_count] = operand;
        stack_count++;
      end
      r.value = top_value();
    end else if (cmd == CMD_ADD || cmd == CMD_SUB || cmd == CMD_MUL || cmd == CMD_DIV) begin
      if (stack_count < 2) begin
        r.status = STAT_UNDER;
      end else begin
        rhs = stack_copy[stack_count-1];
        lhs = stack_copy[stack_count-2];
        case (cmd)
          CMD_ADD: res = lhs + rhs;
          CMD_SUB: res = lhs - rhs;
          CMD_MUL: res = lhs * rhs;
          default: begin
            if (rhs == 0) begin
              res_ok = 1'b0;
              r.status = STAT_DIVZ;
            end else if (lhs == MOST_NEG && rhs == -1) begin
              // The quotient does not fit and wraps back to the most negative value.
              res = MOST_NEG;
            end else begin
              res = lhs / rhs;
            end
          end
        endcase
        if (res_ok) begin
          stack_count--;
          stack_copy[stack_count-1] = res;
        end
      end
      r.value = top_value();
    end else if (cmd == CMD_PRINT) begin
      if (stack_count == 0) begin
        r.status = STAT_UNDER;
      end else begin
        stack_count--;
        r.value = stack_copy[stack_count];
        r.printed = 1'b1;
      end
    end else begin
      r.value = top_value();
    end
    r.depth = DEPTH_OUT_W'(stack_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] wanted, logic [31:0] seen);
    if (errors < MAX_REPORTED) begin
      $display("%0t checker: %s: expected %0h, got %0h", $time, what, wanted, seen);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    calc_result_t want;
    if (!rst_n) begin
      owed_q.delete();
      stack_count = 0;
      results_owed <= 0;
    end else begin
      // Results always come after their instruction's acceptance, so the
      // result side is handled first.
      if (out_mon.valid && out_mon.ready) begin
        if (owed_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", '0, out_mon.result_value);
        end else begin
          want = owed_q.pop_front();
          if (out_mon.status !== want.status)
            report_mismatch("status", want.status, out_mon.status);
          if (out_mon.printed !== want.printed)
            report_mismatch("printed", want.printed, out_mon.printed);
          if (out_mon.result_value !== want.value)
            report_mismatch("result_value", want.value, out_mon.result_value);
          if (out_mon.stack_depth !== want.depth)
            report_mismatch("stack_depth", want.depth, out_mon.stack_depth);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        owed_q.push_back(apply_instruction(in_mon.cmd, in_mon.operand));
      end
      results_owed <= owed_q.size();
    end
  end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// RPN stack calculator testbench
// Drives instruction transactions into the calculator, throttles the result
// channel, and lets the result checker predict and compare every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import rpn_pkg::*;

  // Command codes six and seven do nothing; they are sent as noise.
  localparam logic [CMD_W-1:0] CMD_NOP_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_NOP_HI = 3'd7;

  localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

  localparam int RESET_CYCLES     = 12;
  // Long enough for the unit to fill its output register and sequencer and
  // then hold its input ready low.
  localparam int HOLD_OFF_CYCLES  = 400;
  // This covers a divide in progress with margin.
  localparam int DRAIN_CYCLES     = 64;
  // Worst legal quiet stretch is the hold-off plus a divide plus a receiver
  // stall, well under this limit.
  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int RANDOM_PER_PHASE = 250;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  rpn_in_if  in_chan ();
  rpn_out_if out_chan ();

  int unsigned mismatch_count;
  int unsigned results_owed;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_request;
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned quiet_cycles = 0;

  rpn_stack_calculator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  rpn_result_checker calc_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // Result receiver. Each time the stimulus bumps hold_request, ready is held
  // low for a long stretch so that the unit backs up into its input channel.
  // Otherwise ready is dropped at random according to recv_idle_pct.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      hold_served <= 0;
      hold_left <= 0;
    end else if (hold_request != hold_served) begin
      hold_served <= hold_request;
      hold_left <= HOLD_OFF_CYCLES;
      out_chan.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a run in which neither channel completes a transaction for this
  // long has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Operands lean toward the extremes and small values, so that overflow,
  // truncation and divide by zero come up often; the rest is full-width noise.
  function automatic logic signed [DATA_W-1:0] pick_operand();
    case ($urandom_range(9))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return -1;
      3:       return 0;
      4, 5:    return DATA_W'(int'($urandom_range(20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_arith();
    return CMD_W'($urandom_range(CMD_DIV, CMD_ADD));
  endfunction

  // Offers one instruction and returns at the edge where it is accepted. Valid
  // is only lowered when the sender decides to idle before the next item, so
  // back-to-back items keep valid high without a glitch.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] operand);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.cmd <= cmd;
    in_chan.operand <= operand;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Mostly well-formed postfix expressions: a run of pushes, enough operators
  // to fold them into one value, and usually a print of that value. The rest
  // is arbitrary commands, which produce underflows and no-ops. No-op codes
  // are not counted toward the item budget.
  task automatic run_random(input int unsigned budget);
    int unsigned      sent;
    int unsigned      terms;
    logic [CMD_W-1:0] noise_cmd;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 80) begin
        terms = $urandom_range(5, 1);
        repeat (terms) send_item(CMD_PUSH, pick_operand());
        repeat (terms - 1) send_item(pick_arith(), pick_operand());
        sent += 2 * terms - 1;
        if ($urandom_range(99) < 80) begin
          send_item(CMD_PRINT, pick_operand());
          sent++;
        end
      end else begin
        noise_cmd = CMD_W'($urandom_range(CMD_NOP_HI, CMD_PUSH));
        send_item(noise_cmd, $urandom);
        if (noise_cmd != CMD_NOP_LO && noise_cmd != CMD_NOP_HI) sent++;
      end
    end
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.cmd = CMD_PUSH;
    in_chan.operand = '0;
    hold_request = 0;
    // First phase: sender idles often, receiver idles most of the time.
    send_idle_pct = 37;
    recv_idle_pct = 81;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: errors on an empty and a one-entry stack, wrapping
    // add, the most negative value divided by minus one, divide by zero,
    // truncating division of mixed signs, wrapping multiply, both no-op codes
    // and a print of the empty stack at the end.
    send_item(CMD_PRINT, MOST_POS);
    send_item(CMD_ADD, 0);
    send_item(CMD_NOP_LO, MOST_NEG);
    send_item(CMD_PUSH, MOST_POS);
    send_item(CMD_SUB, 0);
    send_item(CMD_PUSH, 1);
    send_item(CMD_ADD, -1);
    send_item(CMD_PUSH, -1);
    send_item(CMD_DIV, 0);
    send_item(CMD_PUSH, 0);
    send_item(CMD_DIV, 0);
    send_item(CMD_PRINT, 0);
    send_item(CMD_PUSH, MOST_NEG);
    send_item(CMD_MUL, 0);
    send_item(CMD_PUSH, -7);
    send_item(CMD_PUSH, 2);
    send_item(CMD_DIV, 0);
    send_item(CMD_SUB, 0);
    send_item(CMD_PUSH, MOST_POS);
    send_item(CMD_MUL, 0);
    send_item(CMD_PUSH, 7);
    send_item(CMD_PUSH, -2);
    send_item(CMD_DIV, 0);
    send_item(CMD_NOP_HI, -1);
    send_item(CMD_PRINT, 0);
    send_item(CMD_PRINT, 0);
    send_item(CMD_PRINT, 0);

    run_random(RANDOM_PER_PHASE);

    // Second phase: roles swapped, opened by a long receiver hold-off while
    // the sender keeps offering instructions.
    send_idle_pct = 81;
    recv_idle_pct <= 37;
    hold_request <= hold_request + 1;
    run_random(RANDOM_PER_PHASE);

    // Third phase: no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_random(RANDOM_PER_PHASE);
    in_chan.valid <= 1'b0;

    // The checker's outstanding count is a registered copy of its queue size.
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    // Any result that shows up now was never asked for.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && results_owed == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
